/* rtl/pgh_pkg.sv */
// ----------------------------------------------------------------------------
// pgh_pkg: shared types and constants of the photogate homing sequencer
// Holds the phase codes, configuration and result records, register map
// and the delay load helper.
// ----------------------------------------------------------------------------
package pgh_pkg;

    localparam int DELAY_BITS = 16;
    localparam int SPEED_W    = 16;
    localparam int CFG_W      = 16;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;

    typedef enum logic [3:0] {
        PH_IDLE         = 4'd0,
        PH_BACKOUT      = 4'd1,
        PH_BACKOUT_WAIT = 4'd2,
        PH_FAST         = 4'd3,
        PH_REVERSE      = 4'd4,
        PH_REVERSE_WAIT = 4'd5,
        PH_CREEP        = 4'd6,
        PH_CONFIRM      = 4'd7,
        PH_SETTLE       = 4'd8,
        PH_ZERO         = 4'd9,
        PH_HOLD_WAIT    = 4'd10,
        PH_HOLD         = 4'd11
    } t_phase;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_SPEED = 2'd1,
        MODE_HOLD  = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        REG_FAST_SPEED    = 3'd0,
        REG_BACKOUT_SPEED = 3'd1,
        REG_SLOW_SPEED    = 3'd2,
        REG_CLEAR_DELAY   = 3'd3,
        REG_CONFIRM_DELAY = 3'd4,
        REG_SETTLE_DELAY  = 3'd5,
        REG_HOLD_DELAY    = 3'd6
    } t_reg_idx;

    localparam logic signed [SPEED_W-1:0] RST_FAST_SPEED    = 16'sd600;
    localparam logic signed [SPEED_W-1:0] RST_BACKOUT_SPEED = -16'sd250;
    localparam logic signed [SPEED_W-1:0] RST_SLOW_SPEED    = 16'sd50;
    localparam logic [CFG_W-1:0] RST_CLEAR_DELAY   = 16'd150;
    localparam logic [CFG_W-1:0] RST_CONFIRM_DELAY = 16'd2;
    localparam logic [CFG_W-1:0] RST_SETTLE_DELAY  = 16'd50;
    localparam logic [CFG_W-1:0] RST_HOLD_DELAY    = 16'd100;

    typedef struct packed {
        logic signed [SPEED_W-1:0] fast_speed;
        logic signed [SPEED_W-1:0] backout_speed;
        logic signed [SPEED_W-1:0] slow_speed;
        logic [CFG_W-1:0]          clear_delay;
        logic [CFG_W-1:0]          confirm_delay;
        logic [CFG_W-1:0]          settle_delay;
        logic [CFG_W-1:0]          hold_delay;
    } t_cfg;

    typedef struct packed {
        logic                      drive_enable;
        t_mode                     drive_mode;
        logic signed [SPEED_W-1:0] speed_cmd;
        logic                      zero_pulse;
        t_phase                    phase;
        logic                      homed;
    } t_result;

    localparam int CMP_W = (DELAY_BITS > CFG_W) ? DELAY_BITS : CFG_W;

    // Delay registers are wider than the counter when DELAY_BITS is small;
    // oversized values saturate at the counter's full scale.
    function automatic logic [DELAY_BITS-1:0] load_delay(input logic [CFG_W-1:0] d);
        logic [CMP_W-1:0] ext;
        logic [CMP_W-1:0] maxv;
        ext  = CMP_W'(d);
        maxv = CMP_W'({DELAY_BITS{1'b1}});
        if (ext > maxv) begin
            return DELAY_BITS'(maxv);
        end else begin
            return DELAY_BITS'(ext);
        end
    endfunction

endpackage

/* rtl/photogate_homing_sequencer.sv */
// ----------------------------------------------------------------------------
// photogate_homing_sequencer: limit switch homing sequence for one axis
// Path: an accepted request passes the input register, then the result
// register, which drives the output; sink back-pressure holds both registers.
// Throughput: one request per cycle while the sink takes commands, set by the single-step phase update.
// Reset: synchronous, active low; phase returns to idle, counters and the
// homed flag clear, and the registers take their default values.
// ----------------------------------------------------------------------------
module photogate_homing_sequencer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // bit 0 start_req, bit 1 gate, bits 7:2 zero
    input  logic [pgh_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // bit 0 drive_enable, 2:1 drive_mode, 18:3 speed_cmd, 19 zero_pulse,
    // 23:20 phase, 24 homed, 31:25 zero
    output logic [pgh_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pgh_pkg::ADDR_W-1:0]          paddr,
    input  logic [pgh_pkg::DATA_W-1:0]          pwdata,
    output logic [pgh_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);
    import pgh_pkg::*;

    t_cfg    cfg;
    t_result res;

    logic    r_in_valid;
    logic    r_start;
    logic    r_gate;
    logic    r_out_valid;
    t_result r_out;
    logic    out_free;
    logic    step;

    pgh_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The result register frees when empty or taken this cycle.
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_start <= i_s_axis_tdata[0];
            r_gate  <= i_s_axis_tdata[1];
        end
    end

    pgh_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_start (r_start),
        .i_gate  (r_gate),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0,
                              r_out.homed,
                              r_out.phase,
                              r_out.zero_pulse,
                              r_out.speed_cmd,
                              r_out.drive_mode,
                              r_out.drive_enable};

endmodule

/* rtl/pgh_cfg_regs.sv */
// ----------------------------------------------------------------------------
// pgh_cfg_regs: configuration register file
// Seven 16-bit registers behind a bus port with zero wait states.
// ----------------------------------------------------------------------------
module pgh_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pgh_pkg::ADDR_W-1:0]   paddr,
    input  logic [pgh_pkg::DATA_W-1:0]   pwdata,
    output logic [pgh_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output pgh_pkg::t_cfg                o_cfg
);
    import pgh_pkg::*;

    t_cfg             r_cfg;
    logic             wr_en;
    logic [2:0]       reg_idx;
    logic [CFG_W-1:0] wval;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wval    = pwdata[CFG_W-1:0];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fast_speed    <= RST_FAST_SPEED;
            r_cfg.backout_speed <= RST_BACKOUT_SPEED;
            r_cfg.slow_speed    <= RST_SLOW_SPEED;
            r_cfg.clear_delay   <= RST_CLEAR_DELAY;
            r_cfg.confirm_delay <= RST_CONFIRM_DELAY;
            r_cfg.settle_delay  <= RST_SETTLE_DELAY;
            r_cfg.hold_delay    <= RST_HOLD_DELAY;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_FAST_SPEED:    r_cfg.fast_speed    <= wval;
                REG_BACKOUT_SPEED: r_cfg.backout_speed <= wval;
                REG_SLOW_SPEED:    r_cfg.slow_speed    <= wval;
                REG_CLEAR_DELAY:   r_cfg.clear_delay   <= wval;
                REG_CONFIRM_DELAY: r_cfg.confirm_delay <= wval;
                REG_SETTLE_DELAY:  r_cfg.settle_delay  <= wval;
                REG_HOLD_DELAY:    r_cfg.hold_delay    <= wval;
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_FAST_SPEED:    prdata = DATA_W'(r_cfg.fast_speed);
            REG_BACKOUT_SPEED: prdata = DATA_W'(r_cfg.backout_speed);
            REG_SLOW_SPEED:    prdata = DATA_W'(r_cfg.slow_speed);
            REG_CLEAR_DELAY:   prdata = DATA_W'(r_cfg.clear_delay);
            REG_CONFIRM_DELAY: prdata = DATA_W'(r_cfg.confirm_delay);
            REG_SETTLE_DELAY:  prdata = DATA_W'(r_cfg.settle_delay);
            REG_HOLD_DELAY:    prdata = DATA_W'(r_cfg.hold_delay);
            default:           prdata = '0;
        endcase
    end

endmodule

/* rtl/pgh_core.sv */
// ----------------------------------------------------------------------------
// pgh_core: homing phase machine
// Advances the phase, delay counter and homed flag by one tick per step
// and forms the drive command for the phase that results.
// ----------------------------------------------------------------------------
module pgh_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_start,
    input  logic             i_gate,
    input  pgh_pkg::t_cfg    i_cfg,
    output pgh_pkg::t_result o_res
);
    import pgh_pkg::*;

    t_phase                r_phase, n_phase;
    logic [DELAY_BITS-1:0] r_count, n_count;
    logic                  r_homed, n_homed;
    logic                  expired;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
            r_homed <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_homed <= n_homed;
        end
    end

    // A wait phase counts down to zero and advances on the tick after that.
    assign expired = (r_count == '0);

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_homed = r_homed;
        unique case (r_phase)
            PH_BACKOUT: begin
                if (!i_gate) begin
                    n_phase = PH_BACKOUT_WAIT;
                    n_count = load_delay(i_cfg.clear_delay);
                end
            end
            PH_BACKOUT_WAIT: begin
                if (expired) n_phase = PH_FAST;
                else n_count = r_count - 1'b1;
            end
            PH_FAST: begin
                if (i_gate) n_phase = PH_REVERSE;
            end
            PH_REVERSE: begin
                if (!i_gate) begin
                    n_phase = PH_REVERSE_WAIT;
                    n_count = load_delay(i_cfg.clear_delay);
                end
            end
            PH_REVERSE_WAIT: begin
                if (expired) n_phase = PH_CREEP;
                else n_count = r_count - 1'b1;
            end
            PH_CREEP: begin
                if (i_gate) begin
                    n_phase = PH_CONFIRM;
                    n_count = load_delay(i_cfg.confirm_delay);
                end
            end
            PH_CONFIRM: begin
                if (expired) begin
                    if (i_gate) begin
                        n_phase = PH_SETTLE;
                        n_count = load_delay(i_cfg.settle_delay);
                    end else begin
                        n_phase = PH_CREEP;
                    end
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            PH_SETTLE: begin
                if (expired) begin
                    n_phase = PH_ZERO;
                    n_homed = 1'b1;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            PH_ZERO: begin
                n_phase = PH_HOLD_WAIT;
                n_count = load_delay(i_cfg.hold_delay);
            end
            PH_HOLD_WAIT: begin
                if (expired) n_phase = PH_HOLD;
                else n_count = r_count - 1'b1;
            end
            PH_HOLD: begin
                n_phase = PH_HOLD;
            end
            default: begin
                // Idle, and any code outside the sequence, waits for a start.
                n_phase = PH_IDLE;
                if (i_start) n_phase = i_gate ? PH_BACKOUT : PH_FAST;
            end
        endcase
    end

    always_comb begin
        o_res.drive_enable = 1'b1;
        o_res.drive_mode   = MODE_SPEED;
        o_res.speed_cmd    = '0;
        o_res.zero_pulse   = 1'b0;
        o_res.phase        = n_phase;
        o_res.homed        = n_homed;
        unique case (n_phase)
            PH_BACKOUT, PH_BACKOUT_WAIT, PH_REVERSE, PH_REVERSE_WAIT:
                o_res.speed_cmd = i_cfg.backout_speed;
            PH_FAST:
                o_res.speed_cmd = i_cfg.fast_speed;
            PH_CREEP, PH_CONFIRM:
                o_res.speed_cmd = i_cfg.slow_speed;
            PH_ZERO:
                o_res.zero_pulse = 1'b1;
            PH_HOLD:
                o_res.drive_mode = MODE_HOLD;
            PH_SETTLE, PH_HOLD_WAIT: ;
            default: begin
                o_res.drive_enable = 1'b0;
                o_res.drive_mode   = MODE_OFF;
            end
        endcase
    end

endmodule

/* test/tb_photogate_homing_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_photogate_homing_sequencer: self-checking bench for the homing sequencer
// Drives tick requests on the input stream and programs the speed and delay
// registers over APB. A scoreboard predicts one drive command per accepted
// request and compares every field of the commands that come back.
// ----------------------------------------------------------------------------
module tb_photogate_homing_sequencer;
    import pgh_pkg::*;

    class homing_scoreboard;
        t_cfg                  cfg;
        t_phase                phase_q;
        logic [DELAY_BITS-1:0] count_q;
        bit                    homed_q;
        t_result               expected_cmds[$];
        int                    faults;

        function new();
            cfg.fast_speed    = RST_FAST_SPEED;
            cfg.backout_speed = RST_BACKOUT_SPEED;
            cfg.slow_speed    = RST_SLOW_SPEED;
            cfg.clear_delay   = RST_CLEAR_DELAY;
            cfg.confirm_delay = RST_CONFIRM_DELAY;
            cfg.settle_delay  = RST_SETTLE_DELAY;
            cfg.hold_delay    = RST_HOLD_DELAY;
            phase_q = PH_IDLE;
            count_q = '0;
            homed_q = 1'b0;
            faults  = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_FAST_SPEED:    cfg.fast_speed    = value;
                REG_BACKOUT_SPEED: cfg.backout_speed = value;
                REG_SLOW_SPEED:    cfg.slow_speed    = value;
                REG_CLEAR_DELAY:   cfg.clear_delay   = value;
                REG_CONFIRM_DELAY: cfg.confirm_delay = value;
                REG_SETTLE_DELAY:  cfg.settle_delay  = value;
                REG_HOLD_DELAY:    cfg.hold_delay    = value;
                default: ;
            endcase
        endfunction

        // A delay that does not fit the counter saturates at its full scale.
        function logic [DELAY_BITS-1:0] delay_ticks(logic [CFG_W-1:0] d);
            longint full;
            full = (longint'(1) << DELAY_BITS) - 1;
            if (longint'(d) > full) begin
                return DELAY_BITS'(full);
            end
            return DELAY_BITS'(d);
        endfunction

        function bit wait_over();
            if (count_q == '0) begin
                return 1'b1;
            end
            count_q = count_q - 1'b1;
            return 1'b0;
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction

        function void note_request(bit start, bit gate);
            t_result cmd;
            case (phase_q)
                PH_BACKOUT: begin
                    if (!gate) begin
                        phase_q = PH_BACKOUT_WAIT;
                        count_q = delay_ticks(cfg.clear_delay);
                    end
                end
                PH_BACKOUT_WAIT: begin
                    if (wait_over()) phase_q = PH_FAST;
                end
                PH_FAST: begin
                    if (gate) phase_q = PH_REVERSE;
                end
                PH_REVERSE: begin
                    if (!gate) begin
                        phase_q = PH_REVERSE_WAIT;
                        count_q = delay_ticks(cfg.clear_delay);
                    end
                end
                PH_REVERSE_WAIT: begin
                    if (wait_over()) phase_q = PH_CREEP;
                end
                PH_CREEP: begin
                    if (gate) begin
                        phase_q = PH_CONFIRM;
                        count_q = delay_ticks(cfg.confirm_delay);
                    end
                end
                PH_CONFIRM: begin
                    if (wait_over()) begin
                        if (gate) begin
                            phase_q = PH_SETTLE;
                            count_q = delay_ticks(cfg.settle_delay);
                        end else begin
                            phase_q = PH_CREEP;
                        end
                    end
                end
                PH_SETTLE: begin
                    if (wait_over()) begin
                        phase_q = PH_ZERO;
                        homed_q = 1'b1;
                    end
                end
                PH_ZERO: begin
                    phase_q = PH_HOLD_WAIT;
                    count_q = delay_ticks(cfg.hold_delay);
                end
                PH_HOLD_WAIT: begin
                    if (wait_over()) phase_q = PH_HOLD;
                end
                PH_HOLD: ;
                default: begin
                    // Idle, and any code outside the sequence, waits for a start.
                    phase_q = PH_IDLE;
                    if (start) begin
                        if (gate) phase_q = PH_BACKOUT;
                        else phase_q = PH_FAST;
                    end
                end
            endcase

            cmd.drive_enable = 1'b1;
            cmd.drive_mode   = MODE_SPEED;
            cmd.speed_cmd    = '0;
            cmd.zero_pulse   = 1'b0;
            case (phase_q)
                PH_BACKOUT, PH_BACKOUT_WAIT, PH_REVERSE, PH_REVERSE_WAIT:
                    cmd.speed_cmd = cfg.backout_speed;
                PH_FAST:              cmd.speed_cmd = cfg.fast_speed;
                PH_CREEP, PH_CONFIRM: cmd.speed_cmd = cfg.slow_speed;
                PH_ZERO:              cmd.zero_pulse = 1'b1;
                PH_HOLD:              cmd.drive_mode = MODE_HOLD;
                PH_SETTLE, PH_HOLD_WAIT: ;
                default: begin
                    cmd.drive_enable = 1'b0;
                    cmd.drive_mode   = MODE_OFF;
                end
            endcase
            cmd.phase = phase_q;
            cmd.homed = homed_q;
            expected_cmds.push_back(cmd);
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                faults++;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] tdata);
            t_result want;
            if (expected_cmds.size() == 0) begin
                $error("drive command 0x%08h arrived with no request outstanding", tdata);
                faults++;
                return;
            end
            want = expected_cmds.pop_front();
            compare_field("drive_enable", want.drive_enable, tdata[0]);
            compare_field("drive_mode", want.drive_mode, tdata[2:1]);
            compare_field("speed_cmd", longint'(want.speed_cmd),
                          longint'($signed(tdata[18:3])));
            compare_field("zero_pulse", want.zero_pulse, tdata[19]);
            compare_field("phase", want.phase, tdata[23:20]);
            compare_field("homed", want.homed, tdata[24]);
        endfunction
    endclass

    localparam logic [2:0] REG_UNMAPPED = 3'd7;
    localparam int RAND_ITEMS  = 1530;
    localparam int CHUNK       = 150;
    localparam int HOME_AT     = 1200;
    localparam int QUIET_AT    = 1350;
    localparam int STUCK_LIMIT = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tvalid;
    logic                   m_tready = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [ADDR_W-1:0]      paddr = '0;
    logic [DATA_W-1:0]      pwdata = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;

    homing_scoreboard sb = new();
    bit gaps_on = 1'b1;
    bit stalls_on = 1'b1;
    bit home_ok = 1'b0;
    int stall_left = 0;
    int stuck_cycles = 0;

    always #1 i_clk = ~i_clk;

    photogate_homing_sequencer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Command sink with bursts of back-pressure.
    always @(negedge i_clk) begin
        if (stalls_on && stall_left == 0 && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 6);
        end
        if (stalls_on && stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            sb.check_result(o_m_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)) begin
                stuck_cycles <= 0;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic send_req(bit start, bit gate);
        @(negedge i_clk);
        s_tdata  <= IN_TDATA_W'({gate, start});
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_request(start, gate);
    endtask

    task automatic idle_gap(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] idx, logic [CFG_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        // Only the low half is a register; the upper half is junk.
        pwdata  <= {16'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [15:0] pick_speed();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_delay(int top);
        if ($urandom_range(0, 3) == 0) begin
            return 16'd0;
        end
        return 16'($urandom_range(1, top));
    endfunction

    // Settle and hold delays may take full scale while the sequence cannot
    // reach them; the settings for the homing stage keep them short.
    task automatic load_settings(bit homing_stage);
        apb_write(REG_FAST_SPEED, pick_speed());
        apb_write(REG_BACKOUT_SPEED, pick_speed());
        apb_write(REG_SLOW_SPEED, pick_speed());
        apb_write(REG_CLEAR_DELAY, pick_delay(30));
        apb_write(REG_CONFIRM_DELAY, pick_delay(homing_stage ? 3 : 6));
        apb_write(REG_SETTLE_DELAY, (!homing_stage && $urandom_range(0, 3) == 0) ?
                  16'hFFFF : pick_delay(40));
        apb_write(REG_HOLD_DELAY, (!homing_stage && $urandom_range(0, 3) == 0) ?
                  16'hFFFF : pick_delay(40));
    endtask

    // The gate level is steered by the predicted phase so that the run moves
    // through the sequence and circles in the creep and confirm loop until homing is allowed.
    function automatic bit pick_gate();
        case (sb.phase_q)
            PH_BACKOUT, PH_REVERSE: return $urandom_range(0, 4) != 0;
            PH_FAST, PH_CREEP:      return $urandom_range(0, 3) == 0;
            PH_CONFIRM: begin
                if (!home_ok && sb.count_q == '0) return 1'b0;
                return 1'($urandom_range(0, 1));
            end
            default: return 1'($urandom_range(0, 1));
        endcase
    endfunction

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Idle with the reset settings, gate both ways.
        send_req(1'b0, 1'b0);
        send_req(1'b0, 1'b1);
        wait_drained();

        apb_write(REG_FAST_SPEED, 16'h7FFF);
        apb_write(REG_BACKOUT_SPEED, 16'h8000);
        apb_write(REG_SLOW_SPEED, 16'h8000);
        apb_write(REG_CLEAR_DELAY, 16'hFFFF);
        apb_write(REG_CONFIRM_DELAY, 16'hFFFF);
        apb_write(REG_SETTLE_DELAY, 16'hFFFF);
        apb_write(REG_HOLD_DELAY, 16'hFFFF);
        apb_write(REG_UNMAPPED, 16'h5A5A);
        send_req(1'b0, 1'b1);
        wait_drained();

        apb_write(REG_FAST_SPEED, 16'h7FFF);
        apb_write(REG_BACKOUT_SPEED, 16'h8000);
        apb_write(REG_SLOW_SPEED, 16'hFFFF);
        apb_write(REG_CLEAR_DELAY, 16'd1);
        apb_write(REG_CONFIRM_DELAY, 16'd0);
        apb_write(REG_SETTLE_DELAY, 16'd3);
        apb_write(REG_HOLD_DELAY, 16'd2);

        // Start with the gate blocked, back out, wait, seek, reverse, wait,
        // creep, then a confirm that finds the gate clear again.
        send_req(1'b1, 1'b1);
        send_req(1'b1, 1'b1);
        send_req(1'b0, 1'b0);
        send_req(1'b1, 1'b1);
        send_req(1'b0, 1'b0);
        send_req(1'b0, 1'b0);
        send_req(1'b1, 1'b1);
        send_req(1'b0, 1'b1);
        send_req(1'b0, 1'b0);
        send_req(1'b1, 1'b0);
        send_req(1'b0, 1'b1);
        send_req(1'b0, 1'b0);
        send_req(1'b0, 1'b1);
        send_req(1'b0, 1'b0);
        send_req(1'b1, 1'b1);
        send_req(1'b0, 1'b0);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % CHUNK == 0) begin
                wait_drained();
                load_settings(n >= HOME_AT);
                home_ok = (n >= HOME_AT);
                // The last part of the run keeps both sides free of idling.
                gaps_on   = (n < QUIET_AT) ? 1'($urandom_range(0, 1)) : 1'b0;
                stalls_on = (n < QUIET_AT) ? 1'($urandom_range(0, 1)) : 1'b0;
            end
            if (n == QUIET_AT) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            if (gaps_on && $urandom_range(0, 3) == 0) begin
                idle_gap($urandom_range(1, 6));
            end
            send_req(1'($urandom_range(0, 1)), pick_gate());
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.faults == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
